/* rtl/core/e2q_pkg.sv */
// Package: widths, CORDIC constants and shared types for the Euler to quaternion block.
package e2q_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int FRACTION_BITS = 15;
    localparam int CORDIC_STEPS  = 16;
    localparam int INNER_BITS    = 31;
    // CORDIC datapath width: Q.31 with headroom for gain growth
    localparam int CW            = 34;
    // residual angle width, units where 2^32 = pi
    localparam int ZW            = 35;
    localparam int OUT_W         = FRACTION_BITS + 1;

    localparam logic signed [CW-1:0] GAIN_Q31 = 34'sd1304065748;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    typedef struct packed {
        cval_t c;
        cval_t s;
    } cs_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
    } angles_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_w;
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
    } quat_t;

    // arctangent of 2^-i, units where 2^32 = pi
    function automatic zval_t atan_step(input int i);
        logic [31:0] t;
        begin
            case (i)
                0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
                2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
                4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
                6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
                8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
                10: t = 32'h000A2F98;  11: t = 32'h000517CC;
                12: t = 32'h00028BE6;  13: t = 32'h000145F3;
                14: t = 32'h0000A2FA;  15: t = 32'h0000517D;
                16: t = 32'h000028BE;  17: t = 32'h0000145F;
                18: t = 32'h00000A30;  19: t = 32'h00000518;
                20: t = 32'h0000028C;  21: t = 32'h00000146;
                22: t = 32'h000000A3;  23: t = 32'h00000051;
                24: t = 32'h00000029;  25: t = 32'h00000014;
                26: t = 32'h0000000A;  27: t = 32'h00000005;
                28: t = 32'h00000003;  29: t = 32'h00000001;
                30: t = 32'h00000001;
                default: t = 32'h00000000;
            endcase
            atan_step = zval_t'({t, 1'b0});
        end
    endfunction

endpackage

/* rtl/core/e2q_stream_if.sv */
// Interface: valid/ready stream channel carrying one word of type T.
interface e2q_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/e2q_cordic.sv */
// Module: one pipelined CORDIC step array giving cosine and sine of a half angle.
module e2q_cordic
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  angle,
    output e2q_pkg::cs_t                           result
);
    localparam int N = e2q_pkg::CORDIC_STEPS;

    e2q_pkg::cval_t x_reg [N+1];
    e2q_pkg::cval_t y_reg [N+1];
    e2q_pkg::zval_t z_reg [N+1];

    // load the half angle: angle * 2^(32-ANGLE_BITS)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= e2q_pkg::GAIN_Q31;
            y_reg[0] <= '0;
            z_reg[0] <= e2q_pkg::zval_t'(angle) <<< (32 - e2q_pkg::ANGLE_BITS);
        end
    end

    // one rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][e2q_pkg::ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - e2q_pkg::atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + e2q_pkg::atan_step(i);
                end
            end
        end
    end

    assign result.c = x_reg[N];
    assign result.s = y_reg[N];
endmodule

/* rtl/core/euler_to_quaternion_top.sv */
// Top level: ZYX Euler angles to Q1.15 unit quaternion, fully pipelined.
// One word per cycle in and out while the output is not stalled; the pipeline has 17 CORDIC
// stages, a pair product, a triple product, the sum and rounding. The pipeline
// advances whenever the output register is empty or being taken, so ready is
// high in every cycle the output side accepts; a stall freezes all stages.
module euler_to_quaternion_top
(
    input  logic clk,
    input  logic rst_n,
    e2q_stream_if.sink   angles,
    e2q_stream_if.source quat
);
    localparam int N   = e2q_pkg::CORDIC_STEPS;
    localparam int LAT = N + 5;
    localparam int CW  = e2q_pkg::CW;
    localparam int PW  = 2 * CW;
    localparam int SH  = e2q_pkg::INNER_BITS - e2q_pkg::FRACTION_BITS;
    localparam int OW  = e2q_pkg::OUT_W;

    logic           en;
    logic [LAT-1:0] vld_reg;
    e2q_pkg::angles_t in_w;
    e2q_pkg::cs_t r_cs, p_cs, y_cs;

    // advance unless the last stage holds a word not taken
    assign en           = !vld_reg[LAT-1] || quat.ready;
    assign angles.ready = en;
    assign quat.valid   = vld_reg[LAT-1];
    assign in_w         = angles.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], angles.valid};
    end

    e2q_cordic u_roll  (.clk(clk), .en(en), .angle(in_w.roll_angle),  .result(r_cs));
    e2q_cordic u_pitch (.clk(clk), .en(en), .angle(in_w.pitch_angle), .result(p_cs));
    e2q_cordic u_yaw   (.clk(clk), .en(en), .angle(in_w.yaw_angle),   .result(y_cs));

    function automatic e2q_pkg::cval_t mulq(input e2q_pkg::cval_t a, input e2q_pkg::cval_t b);
        logic signed [PW-1:0] p;
        begin
            p    = PW'(a) * PW'(b);
            mulq = e2q_pkg::cval_t'(p >>> e2q_pkg::INNER_BITS);
        end
    endfunction

    // pair products of yaw and pitch, roll terms carried along
    e2q_pkg::cval_t cycp_reg, sysp_reg, sycp_reg, cysp_reg, cr_reg, sr_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycp_reg <= mulq(y_cs.c, p_cs.c);
            sysp_reg <= mulq(y_cs.s, p_cs.s);
            sycp_reg <= mulq(y_cs.s, p_cs.c);
            cysp_reg <= mulq(y_cs.c, p_cs.s);
            cr_reg   <= r_cs.c;
            sr_reg   <= r_cs.s;
        end
    end

    // triple products
    e2q_pkg::cval_t t_reg [8];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= mulq(cycp_reg, cr_reg);
            t_reg[1] <= mulq(sysp_reg, sr_reg);
            t_reg[2] <= mulq(cycp_reg, sr_reg);
            t_reg[3] <= mulq(sysp_reg, cr_reg);
            t_reg[4] <= mulq(sycp_reg, sr_reg);
            t_reg[5] <= mulq(cysp_reg, cr_reg);
            t_reg[6] <= mulq(sycp_reg, cr_reg);
            t_reg[7] <= mulq(cysp_reg, sr_reg);
        end
    end

    // sums with rounding offset
    logic signed [CW:0] s_reg [4];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= (CW+1)'(t_reg[0]) + (CW+1)'(t_reg[1]) + (CW+1)'(1 << (SH-1));
            s_reg[1] <= (CW+1)'(t_reg[2]) - (CW+1)'(t_reg[3]) + (CW+1)'(1 << (SH-1));
            s_reg[2] <= (CW+1)'(t_reg[4]) + (CW+1)'(t_reg[5]) + (CW+1)'(1 << (SH-1));
            s_reg[3] <= (CW+1)'(t_reg[6]) - (CW+1)'(t_reg[7]) + (CW+1)'(1 << (SH-1));
        end
    end

    function automatic logic signed [OW-1:0] sat(input logic signed [CW:0] v);
        logic signed [CW:0] q;
        begin
            q = v >>> SH;
            if (q > (CW+1)'((1 << (OW-1)) - 1))
                sat = OW'((1 << (OW-1)) - 1);
            else if (q < -(CW+1)'(1 << (OW-1)))
                sat = OW'(1 << (OW-1));
            else
                sat = q[OW-1:0];
        end
    endfunction

    // shift, clamp and hold the output word
    e2q_pkg::quat_t q_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg.quat_w <= sat(s_reg[0]);
            q_reg.quat_x <= sat(s_reg[1]);
            q_reg.quat_y <= sat(s_reg[2]);
            q_reg.quat_z <= sat(s_reg[3]);
        end
    end
    assign quat.data = q_reg;
endmodule
